// ===== sv/assert_macros.svh =====
// Assertion helpers for the RTL; psfs_back includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define PSFS_ASSERT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define PSFS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== sv/psfs_pkg.sv =====
// ----------------------------------------------------------------------------
// psfs_pkg
// Types and constants of the per-source IP flow statistics block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package psfs_pkg;

  typedef enum logic [1:0] {
    FUNC_PKT    = 2'd0,
    FUNC_READ   = 2'd1,
    FUNC_TOTALS = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_ENTRY  = 2'd1,
    KIND_FLOW   = 2'd2,
    KIND_TOTALS = 2'd3
  } rkind_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_IGNORED = 2'd2,
    STAT_UNUSED  = 2'd3
  } stat_e;

  typedef enum logic [1:0] {
    DK_UNICAST   = 2'd0,
    DK_BROADCAST = 2'd1,
    DK_MULTICAST = 2'd2
  } dkind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_FLOW_RD,
    ST_FLOW_CHK,
    ST_SHOW_ENT,
    ST_SHOW_ENT_W,
    ST_SHOW_FL,
    ST_SHOW_FL_W,
    ST_EMIT
  } state_e;

  localparam logic [7:0]  PROTO_TCP   = 8'd6;
  localparam logic [7:0]  PROTO_UDP   = 8'd17;
  localparam logic [15:0] MIN_FRAME   = 16'd34;
  localparam logic [8:0]  ETH_HDR     = 9'd14;
  localparam logic [8:0]  L4_PORT_END = 9'd4;
  localparam logic [7:0]  MCAST_LO    = 8'd224;
  localparam logic [7:0]  MCAST_HI    = 8'd239;

  // Classified item passed from front to back.
  typedef struct packed {
    func_e       func;
    logic        ignored;
    logic [15:0] flen;
    logic [7:0]  proto;
    logic [31:0] src;
    logic [15:0] port;
    dkind_e      fkind;
    logic [7:0]  idx;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  proto;
    logic [15:0] port;
    dkind_e      fkind;
    logic [63:0] pkts;
  } flow_t;

  typedef struct packed {
    rkind_e      kind;
    stat_e       status;
    logic [31:0] ip;
    logic [63:0] bytes;
    logic [63:0] pkts;
    logic [7:0]  proto;
    logic [15:0] port;
    dkind_e      fkind;
    logic [2:0]  nflows;
    logic [8:0]  used;
    logic        last;
  } res_t;

endpackage

// ===== sv/psfs_ram.sv =====
// ----------------------------------------------------------------------------
// psfs_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module psfs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== sv/psfs_front.sv =====
// ----------------------------------------------------------------------------
// psfs_front
// Input side: accept items, classify packets, buffer them in a 2-entry queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module psfs_front #(
  parameter int CAPTURE_BYTES = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         func_i,
  input  logic [15:0]        frame_len_i,
  input  logic               is_outgoing_i,
  input  logic [7:0]         ver_ihl_i,
  input  logic [7:0]         protocol_i,
  input  logic [31:0]        src_ip_i,
  input  logic [31:0]        dst_ip_i,
  input  logic [15:0]        port_bytes_i,
  input  logic [7:0]         entry_index_i,
  output logic               q_valid_o,
  output psfs_pkg::cmd_t     q_item_o,
  input  logic               q_pop_i
);
  import psfs_pkg::*;

  localparam logic [8:0] CapLim = 9'(CAPTURE_BYTES);

  cmd_t       slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  cmd_t       cmd;
  logic       known;
  logic       push;
  logic [8:0] need;
  logic       port_ok;

  always_comb begin
    need    = ETH_HDR + {3'b000, ver_ihl_i[3:0], 2'b00} + L4_PORT_END;
    port_ok = (protocol_i == PROTO_TCP || protocol_i == PROTO_UDP) &&
              (frame_len_i >= 16'(need)) && (need <= CapLim);
    known   = 1'b1;
    cmd.func    = FUNC_PKT;
    cmd.ignored = is_outgoing_i || (frame_len_i < MIN_FRAME);
    cmd.flen    = frame_len_i;
    cmd.proto   = protocol_i;
    cmd.src     = src_ip_i;
    cmd.port    = port_ok ? port_bytes_i : 16'd0;
    cmd.idx     = entry_index_i;
    if (dst_ip_i[7:0] == 8'hFF) begin
      cmd.fkind = DK_BROADCAST;
    end else if (dst_ip_i[31:24] inside {[MCAST_LO:MCAST_HI]}) begin
      cmd.fkind = DK_MULTICAST;
    end else begin
      cmd.fkind = DK_UNICAST;
    end
    case (func_i)
      FUNC_PKT:    cmd.func = FUNC_PKT;
      FUNC_READ:   cmd.func = FUNC_READ;
      FUNC_TOTALS: cmd.func = FUNC_TOTALS;
      default:     known = 1'b0;
    endcase
  end

  assign in_stall_o = (cnt_q == 2'd2);
  // drop unknown functions at the door
  assign push       = in_valid_i && !in_stall_o && known;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (q_pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(q_pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= cmd;
    end
  end

endmodule

// ===== sv/psfs_back.sv =====
// ----------------------------------------------------------------------------
// psfs_back
// Execution side: table scan, flow match, entry read-out and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module psfs_back #(
  parameter int DEPTH = 256,
  parameter int FLOWS = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  psfs_pkg::cmd_t q_item_i,
  output logic           q_pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output psfs_pkg::res_t out_res_o
);
  import psfs_pkg::*;

  localparam int EIW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int UW    = $clog2(DEPTH + 1);
  localparam int FCW   = $clog2(FLOWS + 1);
  localparam int NSLOT = DEPTH * FLOWS;
  localparam int SAW   = (NSLOT > 1) ? $clog2(NSLOT) : 1;
  localparam int EWW   = 160 + FCW;
  localparam int FWW   = $bits(flow_t);

  state_e st_q, st_d;
  cmd_t   cmd_q;
  logic [UW-1:0]  used_q, ent_i_q;
  logic [FCW-1:0] slot_q;
  logic           more_q;
  logic [63:0]    tot_bytes_q, tot_pkts_q;
  logic [31:0]    ent_ip_q;
  logic [63:0]    ent_bytes_q, ent_pkts_q;
  logic [FCW-1:0] ent_fcnt_q;
  res_t           res_q, res_d, out_q, out_d;
  logic           res_ld;
  logic           out_valid_q;
  logic           out_free, out_ld;

  logic           ent_re, ent_we;
  logic [EWW-1:0] ent_wdata, ent_rdata;
  logic           fl_re, fl_we;
  logic [FWW-1:0] fl_wdata, fl_rdata;
  logic [SAW-1:0] slot_addr;

  logic [31:0]    rd_ip;
  logic [63:0]    rd_bytes, rd_pkts;
  logic [FCW-1:0] rd_fcnt;
  flow_t          rd_flow;
  logic           scan_done, table_full, ip_hit;
  logic           flow_done, flow_room, flow_hit, idx_unused;

  assign rd_ip    = ent_rdata[FCW+159:FCW+128];
  assign rd_bytes = ent_rdata[FCW+127:FCW+64];
  assign rd_pkts  = ent_rdata[FCW+63:FCW];
  assign rd_fcnt  = ent_rdata[FCW-1:0];
  assign rd_flow  = flow_t'(fl_rdata);

  assign scan_done  = (ent_i_q == used_q);
  assign table_full = (used_q == UW'(DEPTH));
  assign ip_hit     = (rd_ip == cmd_q.src);
  assign flow_done  = (slot_q == ent_fcnt_q);
  assign flow_room  = (ent_fcnt_q < FCW'(FLOWS));
  assign flow_hit   = (rd_flow.proto == cmd_q.proto) && (rd_flow.port == cmd_q.port) &&
                      (rd_flow.fkind == cmd_q.fkind);
  assign idx_unused = (32'(q_item_i.idx) >= 32'(used_q));
  assign slot_addr  = SAW'(32'(ent_i_q[EIW-1:0]) * 32'(FLOWS) + 32'(slot_q));
  assign out_free   = !out_valid_q || !out_stall_i;
  assign out_ld     = (st_q == ST_EMIT) && out_free;

  psfs_ram #(.WIDTH(EWW), .DEPTH(DEPTH)) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_i_q[EIW-1:0]),
    .wdata_i (ent_wdata),
    .re_i    (ent_re),
    .raddr_i (ent_i_q[EIW-1:0]),
    .rdata_o (ent_rdata)
  );

  psfs_ram #(.WIDTH(FWW), .DEPTH(NSLOT)) u_flow_ram (
    .clk_i   (clk_i),
    .we_i    (fl_we),
    .waddr_i (slot_addr),
    .wdata_i (fl_wdata),
    .re_i    (fl_re),
    .raddr_i (slot_addr),
    .rdata_o (fl_rdata)
  );

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          case (q_item_i.func)
            FUNC_PKT:    st_d = q_item_i.ignored ? ST_EMIT : ST_SCAN_RD;
            FUNC_READ:   st_d = idx_unused ? ST_EMIT : ST_SHOW_ENT;
            FUNC_TOTALS: st_d = ST_EMIT;
            default:     st_d = ST_IDLE;
          endcase
        end
      end
      ST_SCAN_RD:    st_d = scan_done ? ST_EMIT : ST_SCAN_CHK;
      ST_SCAN_CHK:   st_d = ip_hit ? ST_FLOW_RD : ST_SCAN_RD;
      ST_FLOW_RD:    st_d = flow_done ? ST_EMIT : ST_FLOW_CHK;
      ST_FLOW_CHK:   st_d = flow_hit ? ST_EMIT : ST_FLOW_RD;
      ST_SHOW_ENT:   st_d = ST_SHOW_ENT_W;
      ST_SHOW_ENT_W: st_d = ST_EMIT;
      ST_SHOW_FL:    st_d = ST_SHOW_FL_W;
      ST_SHOW_FL_W:  st_d = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          st_d = more_q ? ST_SHOW_FL : ST_IDLE;
        end
      end
      default:       st_d = ST_IDLE;
    endcase
  end

  // memory controls and result build
  always_comb begin
    q_pop_o   = 1'b0;
    ent_re    = 1'b0;
    ent_we    = 1'b0;
    ent_wdata = {ent_ip_q, ent_bytes_q, ent_pkts_q, ent_fcnt_q};
    fl_re     = 1'b0;
    fl_we     = 1'b0;
    fl_wdata  = {cmd_q.proto, cmd_q.port, cmd_q.fkind, 64'd1};
    res_ld    = 1'b0;
    res_d     = '0;
    res_d.last = 1'b1;
    case (st_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          res_ld  = 1'b1;
          case (q_item_i.func)
            FUNC_PKT:  res_d.status = STAT_IGNORED;
            FUNC_READ: begin
              res_d.kind   = KIND_ENTRY;
              res_d.status = STAT_UNUSED;
            end
            FUNC_TOTALS: begin
              res_d.kind  = KIND_TOTALS;
              res_d.bytes = tot_bytes_q;
              res_d.pkts  = tot_pkts_q;
            end
            default: res_ld = 1'b0;
          endcase
        end
      end
      ST_SCAN_RD: begin
        if (scan_done) begin
          res_ld       = 1'b1;
          res_d.status = table_full ? STAT_FULL : STAT_OK;
          if (!table_full) begin
            // append a fresh entry with its first flow
            ent_we    = 1'b1;
            ent_wdata = {cmd_q.src, 48'd0, cmd_q.flen, 64'd1, FCW'(1)};
            fl_we     = 1'b1;
          end
        end else begin
          ent_re = 1'b1;
        end
      end
      ST_FLOW_RD: begin
        if (flow_done) begin
          res_ld = 1'b1;
          ent_we = 1'b1;
          if (flow_room) begin
            fl_we     = 1'b1;
            ent_wdata = {ent_ip_q, ent_bytes_q, ent_pkts_q, ent_fcnt_q + FCW'(1)};
          end
        end else begin
          fl_re = 1'b1;
        end
      end
      ST_FLOW_CHK: begin
        if (flow_hit) begin
          res_ld   = 1'b1;
          ent_we   = 1'b1;
          fl_we    = 1'b1;
          fl_wdata = {rd_flow.proto, rd_flow.port, rd_flow.fkind, rd_flow.pkts + 64'd1};
        end
      end
      ST_SHOW_ENT: ent_re = 1'b1;
      ST_SHOW_ENT_W: begin
        res_ld       = 1'b1;
        res_d.kind   = KIND_ENTRY;
        res_d.ip     = rd_ip;
        res_d.bytes  = rd_bytes;
        res_d.pkts   = rd_pkts;
        res_d.nflows = 3'(rd_fcnt);
        res_d.last   = (rd_fcnt == '0);
      end
      ST_SHOW_FL: fl_re = 1'b1;
      ST_SHOW_FL_W: begin
        res_ld       = 1'b1;
        res_d.kind   = KIND_FLOW;
        res_d.ip     = ent_ip_q;
        res_d.pkts   = rd_flow.pkts;
        res_d.proto  = rd_flow.proto;
        res_d.port   = rd_flow.port;
        res_d.fkind  = rd_flow.fkind;
        res_d.nflows = 3'(ent_fcnt_q);
        res_d.last   = (slot_q + FCW'(1) == ent_fcnt_q);
      end
      default: res_ld = 1'b0;
    endcase
  end

  // stamp the entry count as it stands when the result leaves
  always_comb begin
    out_d      = res_q;
    out_d.used = 9'(used_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      used_q      <= '0;
      ent_i_q     <= '0;
      slot_q      <= '0;
      more_q      <= 1'b0;
      tot_bytes_q <= '0;
      tot_pkts_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      case (st_q)
        ST_IDLE: begin
          if (q_valid_i) begin
            ent_i_q <= (q_item_i.func == FUNC_READ) ? UW'(q_item_i.idx) : '0;
            slot_q  <= '0;
            more_q  <= 1'b0;
            if (q_item_i.func == FUNC_PKT && !q_item_i.ignored) begin
              tot_bytes_q <= tot_bytes_q + 64'(q_item_i.flen);
              tot_pkts_q  <= tot_pkts_q + 64'd1;
            end
          end
        end
        ST_SCAN_RD: begin
          if (scan_done && !table_full) begin
            used_q <= used_q + UW'(1);
          end
        end
        ST_SCAN_CHK: begin
          if (!ip_hit) begin
            ent_i_q <= ent_i_q + UW'(1);
          end
        end
        ST_FLOW_CHK: begin
          if (!flow_hit) begin
            slot_q <= slot_q + FCW'(1);
          end
        end
        ST_SHOW_ENT_W: begin
          more_q <= (rd_fcnt != '0);
          slot_q <= '0;
        end
        ST_SHOW_FL_W: begin
          more_q <= (slot_q + FCW'(1) != ent_fcnt_q);
          slot_q <= slot_q + FCW'(1);
        end
        default: ;
      endcase
      if (out_ld) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cmd_q <= q_item_i;
    end
    if (res_ld) begin
      res_q <= res_d;
    end
    if (st_q == ST_SCAN_CHK && ip_hit) begin
      ent_ip_q    <= rd_ip;
      ent_bytes_q <= rd_bytes + 64'(cmd_q.flen);
      ent_pkts_q  <= rd_pkts + 64'd1;
      ent_fcnt_q  <= rd_fcnt;
    end
    if (st_q == ST_SHOW_ENT_W) begin
      ent_ip_q    <= rd_ip;
      ent_bytes_q <= rd_bytes;
      ent_pkts_q  <= rd_pkts;
      ent_fcnt_q  <= rd_fcnt;
    end
    if (out_ld) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  `PSFS_ASSERT(a_used_bound, clk_i, rst_ni, 1'b1, used_q <= UW'(DEPTH))
  `PSFS_ASSERT(a_used_step, clk_i, rst_ni, used_q != $past(used_q), used_q == $past(used_q) + UW'(1))
  `PSFS_ASSERT(a_out_from_emit, clk_i, rst_ni, $rose(out_valid_q), $past(st_q) == ST_EMIT)
  `PSFS_ASSERT(a_fcnt_bound, clk_i, rst_ni, st_q == ST_FLOW_RD, ent_fcnt_q <= FCW'(FLOWS))
  `PSFS_ASSERT_NEXT(a_pop_leaves_idle, clk_i, rst_ni, q_pop_o, st_q != ST_IDLE)

endmodule

// ===== sv/per_source_ip_flow_statistics.sv =====
// ----------------------------------------------------------------------------
// per_source_ip_flow_statistics
// Per-source IPv4 traffic counter table with per-source flow lists.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one item: a packet update,
//   an entry read or a totals read. Output channel (out_valid_o / out_stall_i)
//   returns result items; last_o marks the final one of each item.
//   A 2-entry queue sits between input and the execution sequencer, so the
//   input keeps accepting while a result waits in the output register.
//   Packet update: the source table is scanned entry by entry through the
//   entry RAM read port (SCAN_RD, SCAN_CHK), then the entry's flow slots
//   through the flow RAM (FLOW_RD, FLOW_CHK). Ignored frames and totals
//   reads go straight from IDLE to EMIT. Entry read: SHOW_ENT, SHOW_ENT_W
//   and EMIT for the summary, then SHOW_FL, SHOW_FL_W and EMIT per flow.
//   Reset clears the counters and the entry count at once; no clearing pass
//   is needed, since every read is bounded by the entry and slot counts.
//   A stalled receiver holds the output register; the sequencer then waits
//   and the queue fills until in_stall_o rises.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module per_source_ip_flow_statistics #(
  parameter int IP_TABLE_DEPTH = 256,
  parameter int FLOWS_PER_IP   = 4,
  parameter int CAPTURE_BYTES  = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic [15:0] frame_len_i,
  input  logic        is_outgoing_i,
  input  logic [7:0]  ver_ihl_i,
  input  logic [7:0]  protocol_i,
  input  logic [31:0] src_ip_i,
  input  logic [31:0] dst_ip_i,
  input  logic [15:0] port_bytes_i,
  input  logic [7:0]  entry_index_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  result_kind_o,
  output logic [1:0]  status_o,
  output logic [31:0] ip_addr_o,
  output logic [63:0] byte_count_o,
  output logic [63:0] packet_count_o,
  output logic [7:0]  flow_protocol_o,
  output logic [15:0] flow_dest_port_o,
  output logic [1:0]  flow_kind_o,
  output logic [2:0]  flows_in_entry_o,
  output logic [8:0]  entries_used_o,
  output logic        last_o
);
  import psfs_pkg::*;

  logic q_valid, q_pop;
  cmd_t q_item;
  res_t res;

  psfs_front #(.CAPTURE_BYTES(CAPTURE_BYTES)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .func_i        (func_i),
    .frame_len_i   (frame_len_i),
    .is_outgoing_i (is_outgoing_i),
    .ver_ihl_i     (ver_ihl_i),
    .protocol_i    (protocol_i),
    .src_ip_i      (src_ip_i),
    .dst_ip_i      (dst_ip_i),
    .port_bytes_i  (port_bytes_i),
    .entry_index_i (entry_index_i),
    .q_valid_o     (q_valid),
    .q_item_o      (q_item),
    .q_pop_i       (q_pop)
  );

  psfs_back #(.DEPTH(IP_TABLE_DEPTH), .FLOWS(FLOWS_PER_IP)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (res)
  );

  assign result_kind_o    = res.kind;
  assign status_o         = res.status;
  assign ip_addr_o        = res.ip;
  assign byte_count_o     = res.bytes;
  assign packet_count_o   = res.pkts;
  assign flow_protocol_o  = res.proto;
  assign flow_dest_port_o = res.port;
  assign flow_kind_o      = res.fkind;
  assign flows_in_entry_o = res.nflows;
  assign entries_used_o   = res.used;
  assign last_o           = res.last;

endmodule

// ===== test/tb_per_source_ip_flow_statistics.sv =====
// ----------------------------------------------------------------------------
// tb_per_source_ip_flow_statistics
// Checks the per-source IPv4 counter table against a behavioral table model:
// directed corner frames, random traffic from a small pool of sources under
// several idle and stall mixes, a long output hold-off and a table fill-up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_per_source_ip_flow_statistics;
  import psfs_pkg::*;

  localparam logic [1:0] FUNC_UNKNOWN = 2'd3;
  localparam int TABLE_DEPTH = 256;
  localparam int SLOTS_PER_SRC = 4;
  localparam int CAPTURE = 64;
  localparam int IDLE_LIMIT = 5000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  func_i = '0;
  logic [15:0] frame_len_i = '0;
  logic        is_outgoing_i = 1'b0;
  logic [7:0]  ver_ihl_i = '0;
  logic [7:0]  protocol_i = '0;
  logic [31:0] src_ip_i = '0;
  logic [31:0] dst_ip_i = '0;
  logic [15:0] port_bytes_i = '0;
  logic [7:0]  entry_index_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  result_kind_o;
  logic [1:0]  status_o;
  logic [31:0] ip_addr_o;
  logic [63:0] byte_count_o;
  logic [63:0] packet_count_o;
  logic [7:0]  flow_protocol_o;
  logic [15:0] flow_dest_port_o;
  logic [1:0]  flow_kind_o;
  logic [2:0]  flows_in_entry_o;
  logic [8:0]  entries_used_o;
  logic        last_o;

  per_source_ip_flow_statistics DUT (.*);

  // Table mirror
  logic [31:0] src_addr [TABLE_DEPTH];
  logic [63:0] src_bytes [TABLE_DEPTH];
  logic [63:0] src_pkts [TABLE_DEPTH];
  int          src_nflows [TABLE_DEPTH];
  logic [7:0]  slot_proto [TABLE_DEPTH*SLOTS_PER_SRC];
  logic [15:0] slot_port [TABLE_DEPTH*SLOTS_PER_SRC];
  dkind_e      slot_kind [TABLE_DEPTH*SLOTS_PER_SRC];
  logic [63:0] slot_pkts [TABLE_DEPTH*SLOTS_PER_SRC];
  int          srcs_used = 0;
  logic [63:0] sum_bytes = '0;
  logic [63:0] sum_pkts = '0;

  res_t        pending_results[$];
  logic [31:0] src_pool[$];
  int          mismatches = 0;
  int          results_seen = 0;
  int          items_sent = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          hold_cycles = 0;
  int          idle_cycles = 0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic res_t make_result(rkind_e kind, stat_e st, logic [31:0] ip,
                                       logic [63:0] bytes, logic [63:0] pkts,
                                       logic [7:0] proto, logic [15:0] port,
                                       dkind_e fk, int nfl, logic lst);
    res_t r;
    r.kind = kind;
    r.status = st;
    r.ip = ip;
    r.bytes = bytes;
    r.pkts = pkts;
    r.proto = proto;
    r.port = port;
    r.fkind = fk;
    r.nflows = nfl[2:0];
    r.used = srcs_used[8:0];
    r.last = lst;
    return r;
  endfunction

  // Update the table mirror for one accepted item and queue its results.
  task automatic predict_counters(logic [1:0] fn, logic [15:0] flen, logic outg,
                                  logic [7:0] vihl, logic [7:0] proto,
                                  logic [31:0] src, logic [31:0] dst,
                                  logic [15:0] pbytes, logic [7:0] idx);
    int          e;
    int          base;
    int          need;
    int          hit;
    logic [15:0] port;
    dkind_e      fk;
    e = -1;
    hit = 0;
    port = '0;
    if (fn == FUNC_PKT) begin
      if (outg || flen < MIN_FRAME) begin
        pending_results.push_back(make_result(KIND_STATUS, STAT_IGNORED, 0, 0, 0, 0, 0,
                                              DK_UNICAST, 0, 1'b1));
        return;
      end
      sum_bytes += flen;
      sum_pkts += 1;
      for (int i = 0; i < srcs_used; i++)
        if (e < 0 && src_addr[i] == src) e = i;
      if (e < 0) begin
        if (srcs_used >= TABLE_DEPTH) begin
          pending_results.push_back(make_result(KIND_STATUS, STAT_FULL, 0, 0, 0, 0, 0,
                                                DK_UNICAST, 0, 1'b1));
          return;
        end
        e = srcs_used++;
        src_addr[e] = src;
        src_bytes[e] = '0;
        src_pkts[e] = '0;
        src_nflows[e] = 0;
      end
      src_bytes[e] += flen;
      src_pkts[e] += 1;
      need = 14 + vihl[3:0] * 4 + 4;
      if ((proto == PROTO_UDP || proto == PROTO_TCP) && flen >= need && need <= CAPTURE)
        port = pbytes;
      if (dst == 32'hFFFF_FFFF || dst[7:0] == 8'hFF) fk = DK_BROADCAST;
      else if (dst[31:24] >= MCAST_LO && dst[31:24] <= MCAST_HI) fk = DK_MULTICAST;
      else fk = DK_UNICAST;
      base = e * SLOTS_PER_SRC;
      for (int i = 0; i < src_nflows[e]; i++)
        if (!hit && slot_proto[base+i] == proto && slot_port[base+i] == port &&
            slot_kind[base+i] == fk) begin
          slot_pkts[base+i] += 1;
          hit = 1;
        end
      if (!hit && src_nflows[e] < SLOTS_PER_SRC) begin
        slot_proto[base+src_nflows[e]] = proto;
        slot_port[base+src_nflows[e]] = port;
        slot_kind[base+src_nflows[e]] = fk;
        slot_pkts[base+src_nflows[e]] = 1;
        src_nflows[e]++;
      end
      pending_results.push_back(make_result(KIND_STATUS, STAT_OK, 0, 0, 0, 0, 0,
                                            DK_UNICAST, 0, 1'b1));
    end else if (fn == FUNC_READ) begin
      if (idx >= srcs_used) begin
        pending_results.push_back(make_result(KIND_ENTRY, STAT_UNUSED, 0, 0, 0, 0, 0,
                                              DK_UNICAST, 0, 1'b1));
        return;
      end
      base = idx * SLOTS_PER_SRC;
      pending_results.push_back(make_result(KIND_ENTRY, STAT_OK, src_addr[idx],
                                            src_bytes[idx], src_pkts[idx], 0, 0,
                                            DK_UNICAST, src_nflows[idx],
                                            src_nflows[idx] == 0));
      for (int i = 0; i < src_nflows[idx]; i++)
        pending_results.push_back(make_result(KIND_FLOW, STAT_OK, src_addr[idx], 0,
                                              slot_pkts[base+i], slot_proto[base+i],
                                              slot_port[base+i], slot_kind[base+i],
                                              src_nflows[idx], i + 1 == src_nflows[idx]));
    end else if (fn == FUNC_TOTALS) begin
      pending_results.push_back(make_result(KIND_TOTALS, STAT_OK, 0, sum_bytes, sum_pkts,
                                            0, 0, DK_UNICAST, 0, 1'b1));
    end
  endtask

  // Offer one item, hold it until accepted, then maybe go idle for a while.
  task automatic send_item(logic [1:0] fn, logic [15:0] flen, logic outg,
                           logic [7:0] vihl, logic [7:0] proto, logic [31:0] src,
                           logic [31:0] dst, logic [15:0] pbytes, logic [7:0] idx);
    in_valid_i <= 1'b1;
    func_i <= fn;
    frame_len_i <= flen;
    is_outgoing_i <= outg;
    ver_ihl_i <= vihl;
    protocol_i <= proto;
    src_ip_i <= src;
    dst_ip_i <= dst;
    port_bytes_i <= pbytes;
    entry_index_i <= idx;
    do @(posedge clk_i); while (in_stall_o);
    predict_counters(fn, flen, outg, vihl, proto, src, dst, pbytes, idx);
    items_sent++;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
  endtask

  task automatic send_packet(logic [15:0] flen, logic [7:0] vihl, logic [7:0] proto,
                             logic [31:0] src, logic [31:0] dst, logic [15:0] pbytes);
    send_item(FUNC_PKT, flen, 1'b0, vihl, proto, src, dst, pbytes, 8'($urandom));
  endtask

  task automatic send_random_item();
    int          r;
    logic [31:0] dst;
    r = $urandom_range(99);
    case ($urandom_range(3))
      0: dst = 32'hFFFF_FFFF;
      1: dst = {8'($urandom_range(239, 224)), 24'($urandom)};
      2: dst = {24'($urandom), 8'hFF};
      default: dst = $urandom;
    endcase
    if (r < 60) begin
      send_item(FUNC_PKT,
                $urandom_range(9) == 0 ? 16'($urandom_range(33)) :
                                         16'($urandom_range(1500, 34)),
                $urandom_range(9) == 0, {4'h4, 4'($urandom_range(15, 5))},
                $urandom_range(3) == 0 ? 8'($urandom) : ($urandom_range(1) ? PROTO_TCP : PROTO_UDP),
                src_pool[$urandom_range(src_pool.size() - 1)], dst,
                16'($urandom_range(3)), 8'($urandom));
    end else if (r < 78) begin
      send_item(FUNC_READ, 16'($urandom), 1'($urandom), 8'($urandom), 8'($urandom),
                $urandom, $urandom, 16'($urandom), 8'($urandom_range(srcs_used + 1)));
    end else if (r < 86) begin
      send_item(FUNC_TOTALS, 16'($urandom), 1'($urandom), 8'($urandom), 8'($urandom),
                $urandom, $urandom, 16'($urandom), 8'($urandom));
    end else begin
      // noise: any field value, unknown func included
      send_item(2'($urandom), 16'($urandom), 1'($urandom), 8'($urandom), 8'($urandom),
                $urandom, $urandom, 16'($urandom), 8'($urandom));
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic test_directed();
    logic [31:0] a;
    a = 32'h0A00_0001;
    send_item(FUNC_TOTALS, 0, 0, 0, 0, 0, 0, 0, 0);
    send_item(FUNC_READ, 0, 0, 0, 0, 0, 0, 0, 8'd0);
    send_item(FUNC_PKT, 16'd1000, 1'b1, 8'h45, PROTO_TCP, a, 32'h0A00_0002, 16'd80, 0);
    send_packet(16'd33, 8'h45, PROTO_TCP, a, 32'h0A00_0002, 16'd80);
    send_packet(16'd0, 8'h45, PROTO_TCP, a, 32'h0A00_0002, 16'd80);
    send_packet(16'd34, 8'h45, PROTO_TCP, a, 32'h0A00_0002, 16'd80);
    send_packet(16'd38, 8'h45, PROTO_TCP, a, 32'h0A00_0002, 16'd80);
    send_packet(16'hFFFF, 8'h45, PROTO_UDP, a, 32'hFFFF_FFFF, 16'hFFFF);
    send_packet(16'd1500, 8'h4F, PROTO_UDP, a, 32'hE000_0001, 16'd53);
    send_packet(16'd60, 8'h45, 8'd1, a, 32'hEFFF_FFFE, 16'd7);
    send_packet(16'd60, 8'h45, PROTO_TCP, a, 32'hF000_0001, 16'd22);
    send_packet(16'd60, 8'h45, PROTO_TCP, a, 32'h0A00_0002, 16'd80);
    send_packet(16'd42, 8'h4B, PROTO_TCP, 32'hFFFF_FFFF, 32'h0A01_02FF, 16'd443);
    send_packet(16'd64, 8'hFF, PROTO_UDP, 32'h0000_0000, 32'hDFFF_FFFF, 16'd9);
    send_item(FUNC_UNKNOWN, 16'd100, 0, 8'h45, PROTO_TCP, a, 0, 0, 0);
    send_item(FUNC_READ, 0, 0, 0, 0, 0, 0, 0, 8'd0);
    send_item(FUNC_READ, 0, 0, 0, 0, 0, 0, 0, 8'd2);
    send_item(FUNC_READ, 0, 0, 0, 0, 0, 0, 0, 8'd3);
    send_item(FUNC_READ, 0, 0, 0, 0, 0, 0, 0, 8'd255);
    send_item(FUNC_TOTALS, 0, 0, 0, 0, 0, 0, 0, 0);
    wait_drained();
  endtask

  task automatic test_random_traffic();
    int sender_pct [4] = '{0, 59, 0, 29};
    int recv_pct [4] = '{0, 0, 59, 29};
    repeat (12) src_pool.push_back($urandom);
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = sender_pct[p];
      stall_pct = recv_pct[p];
      repeat (10) send_random_item();
      wait_drained();
    end
    send_idle_pct = 0;
    stall_pct = 0;
  endtask

  task automatic test_output_holdoff();
    hold_cycles = 400;
    repeat (8) send_random_item();
    wait_drained();
  endtask

  task automatic test_table_full();
    while (srcs_used < TABLE_DEPTH)
      send_packet(16'($urandom_range(1500, 34)), 8'h45, PROTO_TCP, $urandom, $urandom, 16'd80);
    repeat (3) send_packet(16'd100, 8'h45, PROTO_UDP, $urandom, 32'h0A00_0001, 16'd5);
    send_packet(16'd200, 8'h45, PROTO_TCP, src_pool[0], 32'h0A00_0001, 16'd80);
    send_item(FUNC_READ, 0, 0, 0, 0, 0, 0, 0, 8'd255);
    send_item(FUNC_READ, 0, 0, 0, 0, 0, 0, 0, 8'd0);
    send_item(FUNC_TOTALS, 0, 0, 0, 0, 0, 0, 0, 0);
    wait_drained();
  endtask

  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result kind=%0d", result_kind_o);
      end else begin
        want = pending_results.pop_front();
        if (result_kind_o !== want.kind || status_o !== want.status ||
            ip_addr_o !== want.ip || byte_count_o !== want.bytes ||
            packet_count_o !== want.pkts || flow_protocol_o !== want.proto ||
            flow_dest_port_o !== want.port || flow_kind_o !== want.fkind ||
            flows_in_entry_o !== want.nflows || entries_used_o !== want.used ||
            last_o !== want.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("exp kind=%0d st=%0d ip=%h by=%h pk=%h pr=%0d po=%0d fk=%0d nf=%0d us=%0d l=%0d",
                     want.kind, want.status, want.ip, want.bytes, want.pkts, want.proto,
                     want.port, want.fkind, want.nflows, want.used, want.last);
            $display("got kind=%0d st=%0d ip=%h by=%h pk=%h pr=%0d po=%0d fk=%0d nf=%0d us=%0d l=%0d",
                     result_kind_o, status_o, ip_addr_o, byte_count_o, packet_count_o,
                     flow_protocol_o, flow_dest_port_o, flow_kind_o, flows_in_entry_o,
                     entries_used_o, last_o);
          end
        end
      end
    end
  end

  // Watchdog: give up after a long stretch with no item moving on either side.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_traffic();
    test_output_holdoff();
    test_table_full();
    $display("Covered %0d items and %0d results: corner frames, random traffic under idle",
             items_sent, results_seen);
    $display("and stall mixes, a long output hold-off and a full source table.");
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
